// File: rtl/core/mhtq_pkg.sv
// shared types and constants for the min-heap timer queue
`timescale 1ns / 1ps

package mhtq_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int TIME_BITS_DEF   = 48;
  localparam int HANDLE_BITS_DEF = 16;

  // widest field widths carried inside the result struct
  localparam int TIME_W   = 48;
  localparam int HANDLE_W = 16;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_EXPIRED  = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_TK_RD,
    S_TK_CMP,
    S_DN_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_RC,
    S_DN_CMP,
    S_FLUSH
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   expiry;
    logic                last;
  } result_t;

endpackage

// File: rtl/core/mhtq_ram.sv
// generic single-clock ram, one write port and one registered read port
`timescale 1ns / 1ps

module mhtq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/mhtq_seq.sv
// heap sequencer: insert with sift-up, tick with pop and sift-down
`timescale 1ns / 1ps

module mhtq_seq #(
  parameter int CAPACITY    = mhtq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS   = mhtq_pkg::TIME_BITS_DEF,
  parameter int HANDLE_BITS = mhtq_pkg::HANDLE_BITS_DEF,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int ENT_W = TIME_BITS + HANDLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   kind_i,
  input  logic [TIME_BITS-1:0]   expire_time_i,
  input  logic [HANDLE_BITS-1:0] client_handle_i,
  input  logic [TIME_BITS-1:0]   now_time_i,
  input  logic                   out_free_i,
  output logic                   emit_o,
  output mhtq_pkg::result_t      result_o,
  output logic                   wr_en_o,
  output logic [IDX_W-1:0]       wr_addr_o,
  output logic [ENT_W-1:0]       wr_data_o,
  output logic                   rd_en_o,
  output logic [IDX_W-1:0]       rd_addr_o,
  input  logic [ENT_W-1:0]       rd_data_i
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KID_W = IDX_W + 2;

  mhtq_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [IDX_W-1:0]     kid_pos_q, kid_pos_d;
  logic [ENT_W-1:0]     cur_q, cur_d;
  logic [ENT_W-1:0]     kid_q, kid_d;
  logic [ENT_W-1:0]     pend_q, pend_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [TIME_BITS-1:0] now_q, now_d;

  logic [TIME_BITS-1:0] rd_time, cur_when, kid_time;
  logic [IDX_W-1:0]     parent;
  logic [KID_W-1:0]     lft, rgt, cnt_ext;
  logic                 idle_ready;

  assign rd_time  = rd_data_i[ENT_W-1:HANDLE_BITS];
  assign cur_when = cur_q[ENT_W-1:HANDLE_BITS];
  assign kid_time = kid_q[ENT_W-1:HANDLE_BITS];
  assign parent   = IDX_W'((pos_q - IDX_W'(1)) >> 1);
  assign lft      = KID_W'({pos_q, 1'b1});
  assign rgt      = lft + KID_W'(1);
  assign cnt_ext  = KID_W'(count_q);

  assign idle_ready = (state_q == mhtq_pkg::S_IDLE) && out_free_i;
  assign in_stall_o = !idle_ready;

  function automatic mhtq_pkg::result_t expired_res(input logic [ENT_W-1:0] ent,
                                                   input logic last);
    mhtq_pkg::result_t r;
    r.status = mhtq_pkg::ST_EXPIRED;
    r.handle = mhtq_pkg::HANDLE_W'(ent[HANDLE_BITS-1:0]);
    r.expiry = mhtq_pkg::TIME_W'(ent[ENT_W-1:HANDLE_BITS]);
    r.last   = last;
    return r;
  endfunction

  function automatic mhtq_pkg::result_t plain_res(input mhtq_pkg::status_e st);
    mhtq_pkg::result_t r;
    r.status = st;
    r.handle = '0;
    r.expiry = '0;
    r.last   = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mhtq_pkg::S_IDLE;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    kid_pos_q <= kid_pos_d;
    cur_q     <= cur_d;
    kid_q     <= kid_d;
    pend_q    <= pend_d;
    now_q     <= now_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    kid_pos_d    = kid_pos_q;
    cur_d        = cur_q;
    kid_d        = kid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    now_d        = now_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = pos_q;
    wr_data_o    = cur_q;
    rd_en_o      = 1'b0;
    rd_addr_o    = '0;
    emit_o       = 1'b0;
    result_o     = plain_res(mhtq_pkg::ST_NONE);

    case (state_q)
      mhtq_pkg::S_IDLE: begin
        if (in_valid_i && idle_ready) begin
          emit_o = 1'b0;
          if (kind_i == mhtq_pkg::KIND_INSERT) begin
            emit_o = 1'b1;
            if (count_q == CNT_W'(CAPACITY)) begin
              result_o = plain_res(mhtq_pkg::ST_FULL);
            end else begin
              // result goes out now, the heap repair follows
              result_o = plain_res(mhtq_pkg::ST_INSERTED);
              cur_d    = {expire_time_i, client_handle_i};
              pos_d    = count_q[IDX_W-1:0];
              count_d  = count_q + CNT_W'(1);
              state_d  = mhtq_pkg::S_UP;
            end
          end else begin
            now_d        = now_time_i;
            pend_valid_d = 1'b0;
            if (count_q == '0) begin
              emit_o = 1'b1;
            end else begin
              rd_en_o = 1'b1;
              state_d = mhtq_pkg::S_TK_CMP;
            end
          end
        end
      end

      mhtq_pkg::S_UP: begin
        if (pos_q == '0) begin
          wr_en_o = 1'b1;
          state_d = mhtq_pkg::S_IDLE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = parent;
          state_d   = mhtq_pkg::S_UP_CMP;
        end
      end

      mhtq_pkg::S_UP_CMP: begin
        wr_en_o = 1'b1;
        if (cur_when < rd_time) begin
          // parent moves down into the hole
          wr_data_o = rd_data_i;
          pos_d     = parent;
          state_d   = mhtq_pkg::S_UP;
        end else begin
          state_d = mhtq_pkg::S_IDLE;
        end
      end

      mhtq_pkg::S_TK_RD: begin
        rd_en_o = 1'b1;
        state_d = mhtq_pkg::S_TK_CMP;
      end

      mhtq_pkg::S_TK_CMP: begin
        // root is on the read port and holds while we wait
        if (out_free_i) begin
          if (rd_time < now_q) begin
            if (pend_valid_q) begin
              emit_o   = 1'b1;
              result_o = expired_res(pend_q, 1'b0);
            end
            pend_d       = rd_data_i;
            pend_valid_d = 1'b1;
            count_d      = count_q - CNT_W'(1);
            if (count_q == CNT_W'(1)) begin
              state_d = mhtq_pkg::S_FLUSH;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = count_d[IDX_W-1:0];
              state_d   = mhtq_pkg::S_DN_LAST;
            end
          end else begin
            emit_o       = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = mhtq_pkg::S_IDLE;
            if (pend_valid_q) begin
              result_o = expired_res(pend_q, 1'b1);
            end
          end
        end
      end

      mhtq_pkg::S_DN_LAST: begin
        cur_d   = rd_data_i;
        pos_d   = '0;
        state_d = mhtq_pkg::S_DN_L;
      end

      mhtq_pkg::S_DN_L: begin
        if (lft >= cnt_ext) begin
          wr_en_o = 1'b1;
          state_d = mhtq_pkg::S_TK_RD;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = lft[IDX_W-1:0];
          state_d   = mhtq_pkg::S_DN_R;
        end
      end

      mhtq_pkg::S_DN_R: begin
        kid_d     = rd_data_i;
        kid_pos_d = lft[IDX_W-1:0];
        if (rgt < cnt_ext) begin
          rd_en_o   = 1'b1;
          rd_addr_o = rgt[IDX_W-1:0];
          state_d   = mhtq_pkg::S_DN_RC;
        end else begin
          state_d = mhtq_pkg::S_DN_CMP;
        end
      end

      mhtq_pkg::S_DN_RC: begin
        // right child wins only on a strictly earlier time
        if (rd_time < kid_time) begin
          kid_d     = rd_data_i;
          kid_pos_d = rgt[IDX_W-1:0];
        end
        state_d = mhtq_pkg::S_DN_CMP;
      end

      mhtq_pkg::S_DN_CMP: begin
        wr_en_o = 1'b1;
        if (kid_time < cur_when) begin
          wr_data_o = kid_q;
          pos_d     = kid_pos_q;
          state_d   = mhtq_pkg::S_DN_L;
        end else begin
          state_d = mhtq_pkg::S_TK_RD;
        end
      end

      mhtq_pkg::S_FLUSH: begin
        if (out_free_i) begin
          emit_o       = 1'b1;
          result_o     = expired_res(pend_q, 1'b1);
          pend_valid_d = 1'b0;
          state_d      = mhtq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = mhtq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/mhtq_outreg.sv
// output register between the sequencer and the result channel
`timescale 1ns / 1ps

module mhtq_outreg #(
  parameter int TIME_BITS   = mhtq_pkg::TIME_BITS_DEF,
  parameter int HANDLE_BITS = mhtq_pkg::HANDLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   emit_i,
  input  mhtq_pkg::result_t      result_i,
  output logic                   out_free_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [HANDLE_BITS-1:0] expired_handle_o,
  output logic [TIME_BITS-1:0]   expired_time_o,
  output logic                   last_o
);

  logic              valid_q, valid_d;
  mhtq_pkg::result_t res_q;

  assign out_free_o = !valid_q || !out_stall_i;
  assign valid_d    = emit_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign status_o         = res_q.status;
  assign expired_handle_o = res_q.handle[HANDLE_BITS-1:0];
  assign expired_time_o   = res_q.expiry[TIME_BITS-1:0];
  assign last_o           = res_q.last;

endmodule

// File: rtl/core/min_heap_timer_queue.sv
// insert: the result is registered in the cycle after acceptance; sift-up then walks
//   S_UP and S_UP_CMP for each parent compared, and writes from S_UP at the root
// tick: on an empty heap the result is registered in the cycle after acceptance; else the
//   root is compared in S_TK_CMP; pops walk the S_DN_ states per level on one read port
// one item at a time: the next item is taken once heap repair is done and out_free is high
// reset clears state, entry count and output valid flag; heap ram contents are not cleared
`timescale 1ns / 1ps

module min_heap_timer_queue #(
  parameter int CAPACITY    = mhtq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS   = mhtq_pkg::TIME_BITS_DEF,
  parameter int HANDLE_BITS = mhtq_pkg::HANDLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   kind_i,
  input  logic [TIME_BITS-1:0]   expire_time_i,
  input  logic [HANDLE_BITS-1:0] client_handle_i,
  input  logic [TIME_BITS-1:0]   now_time_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [HANDLE_BITS-1:0] expired_handle_o,
  output logic [TIME_BITS-1:0]   expired_time_o,
  output logic                   last_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int ENT_W = TIME_BITS + HANDLE_BITS;

  logic              out_free;
  logic              emit;
  mhtq_pkg::result_t result;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [ENT_W-1:0]  wr_data, rd_data;

  mhtq_seq #(
    .CAPACITY   (CAPACITY),
    .TIME_BITS  (TIME_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .expire_time_i  (expire_time_i),
    .client_handle_i(client_handle_i),
    .now_time_i     (now_time_i),
    .out_free_i     (out_free),
    .emit_o         (emit),
    .result_o       (result),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data)
  );

  mhtq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  mhtq_outreg #(
    .TIME_BITS  (TIME_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_outreg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .emit_i          (emit),
    .result_i        (result),
    .out_free_o      (out_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .expired_handle_o(expired_handle_o),
    .expired_time_o  (expired_time_o),
    .last_o          (last_o)
  );

endmodule

// File: rtl/core/mhtq_checker.sv
// port-level checks for the min-heap timer queue, bound to the top level
`timescale 1ns / 1ps

module mhtq_checker #(
  parameter int TIME_BITS   = mhtq_pkg::TIME_BITS_DEF,
  parameter int HANDLE_BITS = mhtq_pkg::HANDLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   kind_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [1:0]             status_o,
  input logic [HANDLE_BITS-1:0] expired_handle_o,
  input logic [TIME_BITS-1:0]   expired_time_o,
  input logic                   last_o
);

  // a stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(expired_handle_o) && $stable(expired_time_o) && $stable(last_o))
  else $error("stalled result changed");

  // every accepted insert is answered in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i == mhtq_pkg::KIND_INSERT |=>
      out_valid_o && last_o &&
      (status_o == mhtq_pkg::ST_INSERTED || status_o == mhtq_pkg::ST_FULL))
  else $error("insert not answered");

  // only an expired entry may be followed by another result of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != mhtq_pkg::ST_EXPIRED |-> last_o)
  else $error("non-expiry result without last");

  // payload is zero on every result that is not an expiry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != mhtq_pkg::ST_EXPIRED |->
      expired_handle_o == '0 && expired_time_o == '0)
  else $error("non-expiry result carries payload");

endmodule

bind min_heap_timer_queue mhtq_checker #(
  .TIME_BITS  (TIME_BITS),
  .HANDLE_BITS(HANDLE_BITS)
) u_mhtq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .kind_i          (kind_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .expired_handle_o(expired_handle_o),
  .expired_time_o  (expired_time_o),
  .last_o          (last_o)
);
